### rtl/tszs_pkg.sv
// Shared types and constants for the temperature scaled zone sequencer.
// No dependencies; imported by every module of the block.

package tszs_pkg;

	localparam int ZONES_DEF      = 4;
	localparam int HIST_DEPTH_DEF = 24;

	localparam int TEMP_W     = 9;
	localparam int HOUR_W     = 5;
	localparam int MINUTE_W   = 6;
	localparam int SECOND_W   = 6;
	localparam int MS_W       = 32;
	localparam int RT_W       = 12;
	localparam int MPS_W      = 13;
	localparam int RUNMIN_W   = 17;
	localparam int PCT_W      = 10;
	localparam int MASK_W     = 4;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 12;

	localparam int MEAN_BIAS    = 40;
	localparam int MPS_GAIN     = 54;
	localparam int MPS_OFFSET   = 300;
	localparam int MPS_MAX      = 8191;
	localparam int MS_PER_MIN   = 60000;
	localparam int PCT_RECIP    = 6554;   // 2^16 / 10, rounded up
	localparam int PCT_RECIP_W  = 13;
	localparam int PCT_SHIFT    = 16;

	// ms / 60000 = (ms >> 5) / 1875; ceil(2^38 / 1875), exact for 27-bit dividends
	localparam int MIN_PRE_SHIFT = 5;
	localparam int MIN_RECIP     = 146601551;
	localparam int MIN_RECIP_W   = 28;
	localparam int MIN_SHIFT     = 38;

	localparam logic [CFG_IDX_W-1:0] CFG_CYC_OFF    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_START_HOUR = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_START_MIN  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_RT0        = 3'd3;

	typedef struct packed {
		logic [HOUR_W-1:0]   hour;
		logic [MINUTE_W-1:0] minute;
		logic [SECOND_W-1:0] second;
		logic [MS_W-1:0]     ms_now;
	} tick_t;

	typedef struct packed {
		logic                cyc_off;
		logic [HOUR_W-1:0]   start_hour;
		logic [MINUTE_W-1:0] start_minute;
	} seq_cfg_t;

	typedef struct packed {
		logic [MASK_W-1:0]   relay_mask;
		logic                zone_started;
		logic                cycle_done;
		logic [RUNMIN_W-1:0] run_minutes;
		logic [PCT_W-1:0]    scale_percent;
		logic                cycle_active;
	} seq_res_t;

endpackage

### rtl/temperature_scaled_zone_sequencer.sv
// Top level of the temperature scaled zone sequencer: handshakes, config
// registers, item control. Depends on tszs_pkg, tszs_hist, tszs_seq.
//
// Usage: one input item per time tick (hour, minute, second, ms_now, temp_f)
// on a valid/ready channel; exactly one result item per tick on a valid/ready
// output channel, in order. Config registers are written through cfg_we,
// cfg_index and cfg_data; the user must do so only while the block is idle,
// which the block itself does not enforce. Unknown indexes are ignored.
// Items are worked one at a time; the next item can be taken as soon as the
// result is in the output register. A tick that stores an hourly sample adds
// the history update and the mean, one quotient bit per cycle. A running
// cycle adds a multiply and an accumulate step per zone scanned through the
// shared multiplier, and the tick that ends the cycle adds the minute count.
// The result sits in an output register; a new item is taken while it waits,
// and the next result is held back until the receiver takes the pending one.
// Reset clears all control state, the config registers to their defaults and
// the history count; history memory entries are never read before written.

module temperature_scaled_zone_sequencer import tszs_pkg::*; #(
	parameter int ZONES         = ZONES_DEF,
	parameter int HISTORY_DEPTH = HIST_DEPTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [HOUR_W-1:0]           clock_hour,
	input  logic [MINUTE_W-1:0]         clock_minute,
	input  logic [SECOND_W-1:0]         clock_second,
	input  logic [MS_W-1:0]             ms_now,
	input  logic signed [TEMP_W-1:0]    temp_f,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [MASK_W-1:0]           relay_mask,
	output logic                        zone_started,
	output logic                        cycle_done,
	output logic [RUNMIN_W-1:0]         run_minutes,
	output logic [PCT_W-1:0]            scale_percent,
	output logic signed [TEMP_W-1:0]    average_temp,
	output logic                        cycle_active,
	input  logic                        cfg_we,
	input  logic [CFG_IDX_W-1:0]        cfg_index,
	input  logic [CFG_DATA_W-1:0]       cfg_data
);

	localparam int ZI_W = (ZONES > 1) ? $clog2(ZONES) : 1;

	typedef enum logic [3:0] {
		T_IDLE = 4'b0001,
		T_HIST = 4'b0010,
		T_SEQ  = 4'b0100,
		T_OUT  = 4'b1000
	} top_state_t;

	top_state_t                 state_q;
	tick_t                      tick_q;
	logic signed [TEMP_W-1:0]   temp_q;
	logic                       hist_start_q;
	seq_cfg_t                   cfg_q;
	logic [ZONES-1:0][RT_W-1:0] runtime_q;
	logic                       hist_done;
	logic signed [TEMP_W-1:0]   mean;
	logic                       seq_done;
	seq_res_t                   seq_res;
	seq_res_t                   out_q;
	logic signed [TEMP_W-1:0]   avg_q;
	logic                       out_valid_q;
	logic                       accept;
	logic                       load;

	assign in_ready = (state_q == T_IDLE);
	assign accept   = in_valid && in_ready;
	assign load     = (state_q == T_OUT) && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.cyc_off      <= 1'b0;
			cfg_q.start_hour   <= HOUR_W'(6);
			cfg_q.start_minute <= '0;
			runtime_q          <= '0;
		end else if (cfg_we) begin
			case (cfg_index) inside
				CFG_CYC_OFF:    cfg_q.cyc_off      <= cfg_data[0];
				CFG_START_HOUR: cfg_q.start_hour   <= cfg_data[HOUR_W-1:0];
				CFG_START_MIN:  cfg_q.start_minute <= cfg_data[MINUTE_W-1:0];
				[CFG_RT0 : CFG_RT0 + CFG_IDX_W'(ZONES - 1)]:
					runtime_q[ZI_W'(cfg_index - CFG_RT0)] <= cfg_data[RT_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			tick_q.hour   <= clock_hour;
			tick_q.minute <= clock_minute;
			tick_q.second <= clock_second;
			tick_q.ms_now <= ms_now;
			temp_q        <= temp_f;
		end
		if (load) begin
			out_q <= seq_res;
			avg_q <= mean;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= T_IDLE;
			hist_start_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			hist_start_q <= accept;
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				T_IDLE: if (accept)    state_q <= T_HIST;
				T_HIST: if (hist_done) state_q <= T_SEQ;
				T_SEQ:  if (seq_done)  state_q <= T_OUT;
				T_OUT:  if (load)      state_q <= T_IDLE;
				default: state_q <= T_IDLE;
			endcase
		end
	end

	tszs_hist #(
		.HISTORY_DEPTH(HISTORY_DEPTH)
	) u_hist (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (hist_start_q),
		.minute (tick_q.minute),
		.second (tick_q.second),
		.temp   (temp_q),
		.done   (hist_done),
		.mean   (mean)
	);

	tszs_seq #(
		.ZONES(ZONES)
	) u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (hist_done),
		.tick    (tick_q),
		.mean    (mean),
		.cfg     (cfg_q),
		.runtime (runtime_q),
		.done    (seq_done),
		.res     (seq_res)
	);

	assign out_valid     = out_valid_q;
	assign relay_mask    = out_q.relay_mask;
	assign zone_started  = out_q.zone_started;
	assign cycle_done    = out_q.cycle_done;
	assign run_minutes   = out_q.run_minutes;
	assign scale_percent = out_q.scale_percent;
	assign cycle_active  = out_q.cycle_active;
	assign average_temp  = avg_q;

endmodule

### rtl/tszs_hist.sv
// Hourly temperature history: sample memory, running sum and a serial
// divider for the truncated mean. Depends on tszs_pkg.

module tszs_hist import tszs_pkg::*; #(
	parameter int HISTORY_DEPTH = HIST_DEPTH_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [MINUTE_W-1:0]      minute,
	input  logic [SECOND_W-1:0]      second,
	input  logic signed [TEMP_W-1:0] temp,
	output logic                     done,
	output logic signed [TEMP_W-1:0] mean
);

	localparam int SUM_W  = $clog2(HISTORY_DEPTH) + TEMP_W;
	localparam int CNT_W  = $clog2(HISTORY_DEPTH + 1);
	localparam int SLOT_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
	localparam int IT_W   = $clog2(SUM_W);

	typedef enum logic [2:0] {
		H_IDLE = 3'b001,
		H_UPD  = 3'b010,
		H_DIV  = 3'b100
	} hist_state_t;

	hist_state_t              state_q;
	logic signed [TEMP_W-1:0] mem [HISTORY_DEPTH];
	logic signed [TEMP_W-1:0] rd_q;
	logic                     wr_en;
	logic [CNT_W-1:0]         count_q;
	logic [SLOT_W-1:0]        slot_q;
	logic signed [SUM_W-1:0]  sum_q;
	logic signed [SUM_W-1:0]  new_sum;
	logic signed [TEMP_W-1:0] mean_q;
	logic                     sampled_q;
	logic                     done_q;
	logic                     neg_q;
	logic [SUM_W-1:0]         quo_q;
	logic [CNT_W-1:0]         rem_q;
	logic [IT_W-1:0]          it_q;
	logic [CNT_W:0]           trial;
	logic                     ge;
	logic [SUM_W-1:0]         quo_nx;
	logic                     full;
	logic                     take;

	assign full    = (count_q == CNT_W'(HISTORY_DEPTH));
	assign take    = (minute == '0) && (second == '0) && !sampled_q;
	assign wr_en   = (state_q == H_UPD);
	assign new_sum = sum_q - (full ? SUM_W'(rd_q) : '0) + SUM_W'(temp);
	assign trial   = {rem_q, quo_q[SUM_W-1]};
	assign ge      = (trial >= {1'b0, count_q});
	assign quo_nx  = {quo_q[SUM_W-2:0], ge};

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[slot_q] <= temp;
		end
		rd_q <= mem[slot_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= H_IDLE;
			count_q   <= '0;
			slot_q    <= '0;
			sum_q     <= '0;
			mean_q    <= '0;
			sampled_q <= 1'b0;
			done_q    <= 1'b0;
			neg_q     <= 1'b0;
			quo_q     <= '0;
			rem_q     <= '0;
			it_q      <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				H_IDLE: begin
					if (start) begin
						if (take) begin
							sampled_q <= 1'b1;
							state_q   <= H_UPD;
						end else begin
							if ((minute == '0) && (second != '0)) begin
								sampled_q <= 1'b0;
							end
							done_q <= 1'b1;
						end
					end
				end
				H_UPD: begin
					if (!full) begin
						count_q <= count_q + 1'b1;
					end
					slot_q <= (slot_q == SLOT_W'(HISTORY_DEPTH - 1)) ? '0 : slot_q + 1'b1;
					sum_q  <= new_sum;
					neg_q  <= new_sum[SUM_W-1];
					quo_q  <= new_sum[SUM_W-1] ? SUM_W'(-new_sum) : SUM_W'(new_sum);
					rem_q  <= '0;
					it_q   <= '0;
					state_q <= H_DIV;
				end
				H_DIV: begin
					rem_q <= ge ? CNT_W'(trial - {1'b0, count_q}) : trial[CNT_W-1:0];
					quo_q <= quo_nx;
					it_q  <= it_q + 1'b1;
					if (it_q == IT_W'(SUM_W - 1)) begin
						mean_q  <= neg_q ? -quo_nx[TEMP_W-1:0] : quo_nx[TEMP_W-1:0];
						done_q  <= 1'b1;
						state_q <= H_IDLE;
					end
				end
				default: state_q <= H_IDLE;
			endcase
		end
	end

	assign done = done_q;
	assign mean = mean_q;

endmodule

### rtl/tszs_seq.sv
// Watering sequencer: cycle start, zone window scan with a shared multiplier,
// reciprocal multiply of the elapsed time into minutes. Depends on tszs_pkg.

module tszs_seq import tszs_pkg::*; #(
	parameter int ZONES = ZONES_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  tick_t                       tick,
	input  logic signed [TEMP_W-1:0]    mean,
	input  seq_cfg_t                    cfg,
	input  logic [ZONES-1:0][RT_W-1:0]  runtime,
	output logic                        done,
	output seq_res_t                    res
);

	localparam int ZI_W    = (ZONES > 1) ? $clog2(ZONES) : 1;
	localparam int PROD_W  = RT_W + MPS_W;
	localparam int BND_W   = PROD_W + ZI_W;
	localparam int MQ_W    = MS_W - MIN_PRE_SHIFT;
	localparam int MIN_PW  = MQ_W + MIN_RECIP_W;
	localparam int PCT_PW  = MPS_W + PCT_RECIP_W;

	typedef enum logic [3:0] {
		Q_IDLE = 4'b0001,
		Q_MUL  = 4'b0010,
		Q_ACC  = 4'b0100,
		Q_MIN  = 4'b1000
	} seq_state_t;

	seq_state_t          state_q;
	logic                running_q;
	logic [MS_W-1:0]     start_ms_q;
	logic [MPS_W-1:0]    mps_q;
	logic [ZONES-1:0]    valves_q;
	logic [MS_W-1:0]     elapsed_q;
	logic [ZI_W-1:0]     idx_q;
	logic [PROD_W-1:0]   prod_q;
	logic [BND_W-1:0]    bound_q;
	logic                done_q;
	seq_res_t            res_q;

	logic                hit;
	logic signed [15:0]  mext;
	logic signed [15:0]  mps_raw;
	logic [MPS_W-1:0]    mps_new;
	logic [BND_W-1:0]    bnd;
	logic [ZONES-1:0]    zone_bit;
	logic [ZONES-1:0]    mask_nx;
	logic [MIN_PW-1:0]   min_prod;
	logic [PCT_PW-1:0]   pct_prod;

	assign hit = (tick.hour == cfg.start_hour) && (tick.minute == cfg.start_minute) &&
		(tick.second == '0) && !running_q;

	always_comb begin
		mext    = 16'(mean);
		mps_raw = (mext - 16'(MEAN_BIAS)) * 16'(MPS_GAIN) + 16'(MPS_OFFSET);
		if (mps_raw < 0) begin
			mps_new = '0;
		end else if (mps_raw > 16'(MPS_MAX)) begin
			mps_new = MPS_W'(MPS_MAX);
		end else begin
			mps_new = mps_raw[MPS_W-1:0];
		end
	end

	assign bnd      = bound_q + BND_W'(prod_q);
	assign zone_bit = ZONES'(1) << idx_q;
	assign mask_nx  = valves_q[idx_q] ? valves_q : zone_bit;
	assign min_prod = MIN_PW'(elapsed_q[MS_W-1:MIN_PRE_SHIFT]) * MIN_PW'(MIN_RECIP);
	assign pct_prod = PCT_PW'(mps_q) * PCT_PW'(PCT_RECIP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= Q_IDLE;
			running_q  <= 1'b0;
			start_ms_q <= '0;
			mps_q      <= '0;
			valves_q   <= '0;
			elapsed_q  <= '0;
			idx_q      <= '0;
			prod_q     <= '0;
			bound_q    <= '0;
			done_q     <= 1'b0;
			res_q      <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				Q_IDLE: begin
					if (start) begin
						if (!cfg.cyc_off && (hit || running_q)) begin
							if (hit) begin
								valves_q   <= '0;
								start_ms_q <= tick.ms_now;
								mps_q      <= mps_new;
								running_q  <= 1'b1;
							end
							elapsed_q <= hit ? '0 : tick.ms_now - start_ms_q;
							idx_q     <= '0;
							bound_q   <= '0;
							state_q   <= Q_MUL;
						end else begin
							done_q              <= 1'b1;
							res_q               <= '0;
							res_q.relay_mask    <= MASK_W'(valves_q);
							res_q.cycle_active  <= running_q;
						end
					end
				end
				Q_MUL: begin
					prod_q  <= PROD_W'(runtime[idx_q]) * PROD_W'(mps_q);
					state_q <= Q_ACC;
				end
				Q_ACC: begin
					bound_q <= bnd;
					if (elapsed_q < MS_W'(bnd)) begin
						valves_q            <= mask_nx;
						done_q              <= 1'b1;
						res_q               <= '0;
						res_q.relay_mask    <= MASK_W'(mask_nx);
						res_q.zone_started  <= !valves_q[idx_q];
						res_q.cycle_active  <= 1'b1;
						state_q             <= Q_IDLE;
					end else if (idx_q == ZI_W'(ZONES - 1)) begin
						valves_q  <= '0;
						running_q <= 1'b0;
						state_q   <= Q_MIN;
					end else begin
						idx_q   <= idx_q + 1'b1;
						state_q <= Q_MUL;
					end
				end
				Q_MIN: begin
					done_q              <= 1'b1;
					res_q               <= '0;
					res_q.cycle_done    <= 1'b1;
					res_q.run_minutes   <= min_prod[MIN_SHIFT +: RUNMIN_W];
					res_q.scale_percent <= pct_prod[PCT_SHIFT +: PCT_W];
					state_q             <= Q_IDLE;
				end
				default: state_q <= Q_IDLE;
			endcase
		end
	end

	assign done = done_q;
	assign res  = res_q;

endmodule

### rtl/tszs_checker.sv
// Port-level checks for the temperature scaled zone sequencer, bound to the
// top level. Depends on tszs_pkg and temperature_scaled_zone_sequencer.

module tszs_checker import tszs_pkg::*; (
	input logic                     clk,
	input logic                     arst_n,
	input logic                     in_valid,
	input logic                     in_ready,
	input logic                     out_valid,
	input logic                     out_ready,
	input logic [MASK_W-1:0]        relay_mask,
	input logic                     zone_started,
	input logic                     cycle_done,
	input logic [RUNMIN_W-1:0]      run_minutes,
	input logic [PCT_W-1:0]         scale_percent,
	input logic signed [TEMP_W-1:0] average_temp,
	input logic                     cycle_active
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(relay_mask) &&
		$stable(run_minutes) && $stable(average_temp) && $stable(cycle_active))
		else $error("result changed while stalled");

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second item taken while one is in work");

	a_done_off: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && cycle_done |-> relay_mask == '0 && !cycle_active && !zone_started)
		else $error("cycle end with valves or activity");

	a_start_hot: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && zone_started |-> $onehot(relay_mask) && cycle_active)
		else $error("zone start without a single valve");

	a_report_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !cycle_done |-> run_minutes == '0 && scale_percent == '0 &&
		$onehot0(relay_mask))
		else $error("report fields set outside cycle end");

endmodule

bind temperature_scaled_zone_sequencer tszs_checker u_tszs_checker (.*);
